// ===== hdl/integer_to_ascii_formatter_defines.svh =====
// Assertion macros used by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// ante holds -> cons holds in the same cycle
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/itoa_fmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itoa_fmt_pkg;

  localparam int OUT_MAX_DEFAULT = 64;
  localparam int VALUE_W         = 64;
  localparam int CHAR_W          = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;
  localparam int BCD_DIGITS      = 20;
  localparam int CNT_W           = $clog2(VALUE_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALTERNATE_FORM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE     = 3'd4;

  // radix codes; codes above RADIX_HEX act as hex
  localparam logic [2:0] RADIX_SDEC = 3'd0;
  localparam logic [2:0] RADIX_UDEC = 3'd1;
  localparam logic [2:0] RADIX_BIN  = 3'd2;
  localparam logic [2:0] RADIX_OCT  = 3'd3;
  localparam logic [2:0] RADIX_HEX  = 3'd4;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_SPACE = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

  typedef struct packed {
    logic [2:0] radix_mode;
    logic [7:0] min_digits;
    logic [1:0] sign_mode;
    logic       alternate_form;
    logic       upper_case;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else begin
      return (upper ? CH_UA : CH_LA) + d8 - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itoa_fmt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  itoa_fmt_pkg::sts_t  sts,
  output itoa_fmt_pkg::cmd_t  cmd,
  output logic                busy
);
  import itoa_fmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIZE = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/itoa_fmt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_fmt_dp #(
  parameter int OUT_MAX = itoa_fmt_pkg::OUT_MAX_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [itoa_fmt_pkg::VALUE_W-1:0]     value_bits,
  input  itoa_fmt_pkg::cfg_t                   cfg,
  input  itoa_fmt_pkg::cmd_t                   cmd,
  output itoa_fmt_pkg::sts_t                   sts,
  output logic [itoa_fmt_pkg::CHAR_W-1:0]      text_char,
  output logic                                 last_char,
  output logic                                 empty_text,
  output logic                                 cut_short,
  output logic                                 strobe
);
  import itoa_fmt_pkg::*;

  localparam int PW = $clog2(OUT_MAX);

  logic [VALUE_W-1:0]          mag;
  logic [VALUE_W-1:0]          sh;
  logic [BCD_DIGITS-1:0][3:0]  bcd;
  logic [6:0]                  bitlen;
  logic [4:0]                  dcount;
  logic                        neg;
  logic                        is_zero;
  logic [6:0]                  ndig;
  logic [6:0]                  nd_total;
  logic [CHAR_W-1:0]           pre_char;
  logic                        empty;
  logic                        cut;
  logic [PW-1:0]               p;

  // conversion step: shift-add-3 across all BCD digits
  logic [BCD_DIGITS-1:0][3:0]  bcd_adj;
  logic [4*BCD_DIGITS-1:0]     adj_flat;
  logic [BCD_DIGITS-1:0][3:0]  bcd_next;
  logic [31:0][3:0]            bcd_next_pad;
  logic [6:0]                  bitlen_next;
  logic [4:0]                  dcount_next;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    adj_flat     = bcd_adj;
    bcd_next     = {adj_flat[4*BCD_DIGITS-2:0], sh[VALUE_W-1]};
    bcd_next_pad = {{(32 - BCD_DIGITS){4'h0}}, bcd_next};
    bitlen_next  = (bitlen != 7'd0 || sh[VALUE_W-1]) ? bitlen + 7'd1 : bitlen;
    dcount_next  = dcount;
    if (dcount < 5'(BCD_DIGITS) && bcd_next_pad[dcount] != 4'd0) begin
      dcount_next = dcount + 5'd1;
    end
  end

  // sizing
  logic [6:0]  md_eff;
  logic [7:0]  oct_tmp;
  logic [13:0] oct_prod;
  logic [7:0]  hex_tmp;
  logic [6:0]  ndig_raw;
  logic [6:0]  ndig_eff;
  logic        padded;
  logic [6:0]  nd_tot;
  logic [1:0]  pre_len;
  logic [CHAR_W-1:0] pre_sel;
  logic [7:0]  len;
  logic        cut_sel;
  logic [PW-1:0] p_start;

  always_comb begin
    md_eff   = cfg.min_digits[7] ? 7'd0 : cfg.min_digits[6:0];
    oct_tmp  = {1'b0, bitlen} + 8'd2;
    oct_prod = 14'(oct_tmp) * 14'd43;
    hex_tmp  = {1'b0, bitlen} + 8'd3;
    case (cfg.radix_mode)
      RADIX_SDEC, RADIX_UDEC: ndig_raw = {2'b0, dcount};
      RADIX_BIN:              ndig_raw = bitlen;
      RADIX_OCT:              ndig_raw = oct_prod[13:7];
      default:                ndig_raw = {1'b0, hex_tmp[7:2]};
    endcase
    ndig_eff = is_zero ? 7'd1 : ndig_raw;
    padded   = !is_zero && (md_eff > ndig_eff);
    nd_tot   = padded ? md_eff : ndig_eff;
    pre_len  = 2'd0;
    pre_sel  = CH_ZERO;
    case (cfg.radix_mode)
      RADIX_SDEC: begin
        if (neg) begin
          pre_len = 2'd1;
          pre_sel = CH_MINUS;
        end else if (cfg.sign_mode == SIGN_SPACE) begin
          pre_len = 2'd1;
          pre_sel = CH_SPACE;
        end else if (cfg.sign_mode == SIGN_PLUS) begin
          pre_len = 2'd1;
          pre_sel = CH_PLUS;
        end
      end
      RADIX_UDEC: begin
        pre_len = 2'd0;
      end
      RADIX_BIN: begin
        if (cfg.alternate_form && !padded) begin
          pre_len = 2'd2;
          pre_sel = CH_LB;
        end
      end
      RADIX_OCT: begin
        if (cfg.alternate_form && !padded) begin
          pre_len = 2'd1;
          pre_sel = CH_ZERO;
        end
      end
      default: begin
        if (cfg.alternate_form) begin
          pre_len = 2'd2;
          pre_sel = cfg.upper_case ? CH_UX : CH_LX;
        end
      end
    endcase
    if (is_zero) begin
      len = (cfg.min_digits == 8'd0) ? 8'd0 : 8'd1;
    end else begin
      len = {1'b0, nd_tot} + {6'b0, pre_len};
    end
    cut_sel = (len > 8'(OUT_MAX));
    p_start = cut_sel ? PW'(OUT_MAX - 1) : PW'(len - 8'd1);
  end

  // character at position p, counted from the end of the text
  logic [7:0]           pe;
  logic [31:0][3:0]     dec_dig;
  logic [31:0][2:0]     oct_dig;
  logic [15:0][3:0]     hex_dig;
  logic [3:0]           dval;
  logic [CHAR_W-1:0]    ch;

  always_comb begin
    pe      = 8'(p);
    dec_dig = {{(32 - BCD_DIGITS){4'h0}}, bcd};
    oct_dig = {32'b0, mag};
    hex_dig = mag;
    case (cfg.radix_mode)
      RADIX_SDEC, RADIX_UDEC: dval = dec_dig[pe[4:0]];
      RADIX_BIN:              dval = {3'b0, mag[pe[5:0]]};
      RADIX_OCT:              dval = {1'b0, oct_dig[pe[4:0]]};
      default:                dval = hex_dig[pe[3:0]];
    endcase
    if (pe < {1'b0, ndig}) begin
      ch = digit_char(dval, cfg.upper_case);
    end else if (pe < {1'b0, nd_total}) begin
      ch = CH_ZERO;
    end else if (pe == {1'b0, nd_total}) begin
      ch = pre_char;
    end else begin
      ch = CH_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= (cfg.radix_mode == RADIX_SDEC) && value_bits[VALUE_W-1];
      mag     <= ((cfg.radix_mode == RADIX_SDEC) && value_bits[VALUE_W-1]) ?
                 (~value_bits) + 64'd1 : value_bits;
      sh      <= ((cfg.radix_mode == RADIX_SDEC) && value_bits[VALUE_W-1]) ?
                 (~value_bits) + 64'd1 : value_bits;
      is_zero <= (value_bits == '0);
      bcd     <= '0;
      bitlen  <= '0;
      dcount  <= '0;
    end
    if (cmd.step) begin
      sh     <= {sh[VALUE_W-2:0], 1'b0};
      bcd    <= bcd_next;
      bitlen <= bitlen_next;
      dcount <= dcount_next;
    end
    if (cmd.size) begin
      ndig     <= ndig_eff;
      nd_total <= nd_tot;
      pre_char <= pre_sel;
      empty    <= (len == 8'd0);
      cut      <= cut_sel;
      p        <= p_start;
    end
    if (cmd.emit) begin
      text_char  <= empty ? CH_NUL : ch;
      last_char  <= empty || (p == '0);
      empty_text <= empty;
      cut_short  <= cut;
      p          <= p - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  assign sts.done = empty || (p == '0);

endmodule

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// Formats a 64-bit value as printf-style integer text (%d, %u, %o, %x, %b with precision,
// sign and alternate-form options) and sends it one character per cycle, most significant
// character first, with last_char on the final one. An item is taken when start is high
// and busy is low. Each value first runs a shift-add-3 binary-to-BCD pass (done for every
// radix, it also finds the digit count), then a sizing step, then sends its characters (at
// most OUT_MAX, and 1 for an empty text). Results arrive on strobe for exactly one cycle
// each, back to back; the receiver cannot stall them and must take every one.
// Write the configuration only while busy is low; the settings are used until the last
// character is out.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter #(
  parameter int OUT_MAX = itoa_fmt_pkg::OUT_MAX_DEFAULT
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    start,
  output logic                                   busy,
  input  wire  [itoa_fmt_pkg::VALUE_W-1:0]       value_bits,
  input  wire                                    wr_en,
  input  wire  [itoa_fmt_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire  [itoa_fmt_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                                   strobe,
  output logic [itoa_fmt_pkg::CHAR_W-1:0]        text_char,
  output logic                                   last_char,
  output logic                                   empty_text,
  output logic                                   cut_short
);
  import itoa_fmt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix_mode     <= RADIX_SDEC;
      cfg.min_digits     <= 8'hFF;
      cfg.sign_mode      <= SIGN_NONE;
      cfg.alternate_form <= 1'b0;
      cfg.upper_case     <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIX_MODE:     cfg.radix_mode     <= wr_data[2:0];
        REG_MIN_DIGITS:     cfg.min_digits     <= wr_data;
        REG_SIGN_MODE:      cfg.sign_mode      <= wr_data[1:0];
        REG_ALTERNATE_FORM: cfg.alternate_form <= wr_data[0];
        REG_UPPER_CASE:     cfg.upper_case     <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  itoa_fmt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  itoa_fmt_dp #(
    .OUT_MAX (OUT_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value_bits (value_bits),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .text_char  (text_char),
    .last_char  (last_char),
    .empty_text (empty_text),
    .cut_short  (cut_short),
    .strobe     (strobe)
  );

  `ASSERT_NEXT_CYCLE(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised")
  `ASSERT_NEXT_CYCLE(a_chars_contiguous, clk, rst, strobe && !last_char, strobe, "gap in text")
  `ASSERT_NEXT_CYCLE(a_last_ends, clk, rst, strobe && last_char, !strobe, "strobe after last")
  `ASSERT_SAME_CYCLE(a_empty, clk, rst, strobe && empty_text, last_char && !cut_short, "bad empty")

endmodule

`default_nettype wire

// ===== tb/sv/integer_to_ascii_formatter_test.sv =====
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
  import itoa_fmt_pkg::*;

  localparam int OUT_LIMIT      = OUT_MAX_DEFAULT;
  localparam int TAIL_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 4000;

  // codes outside the defined set
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
  localparam logic [2:0]           RADIX_SPARE = 3'd7;
  localparam logic [1:0]           SIGN_SPARE  = 2'd3;

  typedef enum logic [1:0] {JOB_VALUE, JOB_WRITE, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                 kind;
    logic [VALUE_W-1:0]        value;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_data;
    int                        gap_pct;
  } format_job_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
    logic              cut;
  } fmt_char_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [VALUE_W-1:0]    value_bits = '0;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = REG_RADIX_MODE;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  busy;
  logic                  strobe;
  logic [CHAR_W-1:0]     text_char;
  logic                  last_char;
  logic                  empty_text;
  logic                  cut_short;

  format_job_t format_jobs[$];
  fmt_char_t   pending_chars[$];
  cfg_t        fmt_cfg = '{radix_mode: RADIX_SDEC, min_digits: 8'hFF, sign_mode: SIGN_NONE,
                           alternate_form: 1'b0, upper_case: 1'b0};
  bit          xfer_in = 1'b0;
  int          errors = 0;
  int          quiet_cycles = 0;
  int          cur_gap = 37;

  integer_to_ascii_formatter dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .strobe     (strobe),
    .text_char  (text_char),
    .last_char  (last_char),
    .empty_text (empty_text),
    .cut_short  (cut_short)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected character stream for one value under the current format settings
  task automatic format_value(input logic [VALUE_W-1:0] raw);
    byte unsigned chars[$];
    logic [VALUE_W-1:0] mag;
    logic [2:0] radix;
    int ndig;
    int floor_n;
    bit neg;
    bit padded;
    bit cut;
    string digits;
    fmt_char_t c;
    radix = fmt_cfg.radix_mode;
    floor_n = int'($signed(fmt_cfg.min_digits));
    digits = fmt_cfg.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";
    mag = raw;
    ndig = 0;
    neg = 1'b0;
    padded = 1'b0;
    if (raw == '0) begin
      if (floor_n != 0) chars.push_front(CH_ZERO);
    end else begin
      if (radix == RADIX_SDEC && raw[VALUE_W-1]) begin
        neg = 1'b1;
        mag = ~raw + 64'd1;
      end
      while (mag != '0) begin
        if (radix <= RADIX_UDEC) begin
          chars.push_front(CH_ZERO + 8'(mag % 64'd10));
          mag = mag / 64'd10;
        end else if (radix == RADIX_BIN) begin
          chars.push_front(CH_ZERO + {7'b0, mag[0]});
          mag = mag >> 1;
        end else if (radix == RADIX_OCT) begin
          chars.push_front(CH_ZERO + {5'b0, mag[2:0]});
          mag = mag >> 3;
        end else begin
          chars.push_front(digits[mag[3:0]]);
          mag = mag >> 4;
        end
        ndig++;
      end
      while (ndig < floor_n) begin
        chars.push_front(CH_ZERO);
        padded = 1'b1;
        ndig++;
      end
      if (radix == RADIX_SDEC) begin
        if (neg) chars.push_front(CH_MINUS);
        else if (fmt_cfg.sign_mode == SIGN_SPACE) chars.push_front(CH_SPACE);
        else if (fmt_cfg.sign_mode == SIGN_PLUS) chars.push_front(CH_PLUS);
      end else if (radix == RADIX_BIN) begin
        if (fmt_cfg.alternate_form && !padded) begin
          chars.push_front(CH_LB);
          chars.push_front(CH_ZERO);
        end
      end else if (radix == RADIX_OCT) begin
        if (fmt_cfg.alternate_form && !padded) chars.push_front(CH_ZERO);
      end else if (radix != RADIX_UDEC) begin
        if (fmt_cfg.alternate_form) begin
          chars.push_front(fmt_cfg.upper_case ? CH_UX : CH_LX);
          chars.push_front(CH_ZERO);
        end
      end
    end
    if (chars.size() == 0) begin
      c.ch = CH_NUL;
      c.last = 1'b1;
      c.empty = 1'b1;
      c.cut = 1'b0;
      pending_chars.push_back(c);
    end else begin
      cut = chars.size() > OUT_LIMIT;
      while (chars.size() > OUT_LIMIT) void'(chars.pop_front());
      foreach (chars[i]) begin
        c.ch = chars[i];
        c.last = (i == chars.size() - 1);
        c.empty = 1'b0;
        c.cut = cut;
        pending_chars.push_back(c);
      end
    end
  endtask

  task automatic put_value(input logic [VALUE_W-1:0] v);
    format_job_t j;
    j.kind = JOB_VALUE;
    j.value = v;
    j.reg_idx = REG_RADIX_MODE;
    j.reg_data = '0;
    j.gap_pct = cur_gap;
    format_jobs.push_back(j);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    format_job_t j;
    j.kind = JOB_WRITE;
    j.value = '0;
    j.reg_idx = idx;
    j.reg_data = data;
    j.gap_pct = 0;
    format_jobs.push_back(j);
  endtask

  task automatic put_drain();
    format_job_t j;
    j.kind = JOB_DRAIN;
    j.value = '0;
    j.reg_idx = REG_RADIX_MODE;
    j.reg_data = '0;
    j.gap_pct = 0;
    format_jobs.push_back(j);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'($urandom_range(0, 20));
      2, 3: v = v >> $urandom_range(1, 63);
      4: v = ~(v >> $urandom_range(1, 63));
      5: v = 64'h1 << $urandom_range(0, 63);
      6: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      7: v = ~64'h0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_min_digits();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'hFF;
      4, 5, 6, 7: return 8'($urandom_range(0, 24));
      8: return 8'($urandom_range(25, 80));
      default: return 8'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin : drive
    format_job_t job;
    logic go;
    logic write_now;
    go = start && !xfer_in;
    write_now = 1'b0;
    if (!rst && !go && format_jobs.size() != 0) begin
      job = format_jobs[0];
      if (job.kind == JOB_VALUE) begin
        if ($urandom_range(0, 99) >= job.gap_pct) begin
          go = 1'b1;
          value_bits <= job.value;
          void'(format_jobs.pop_front());
        end
      end else if (pending_chars.size() == 0 && !busy) begin
        if (job.kind == JOB_WRITE) begin
          write_now = 1'b1;
          wr_index <= job.reg_idx;
          wr_data <= job.reg_data;
          case (job.reg_idx)
            REG_RADIX_MODE:     fmt_cfg.radix_mode = job.reg_data[2:0];
            REG_MIN_DIGITS:     fmt_cfg.min_digits = job.reg_data;
            REG_SIGN_MODE:      fmt_cfg.sign_mode = job.reg_data[1:0];
            REG_ALTERNATE_FORM: fmt_cfg.alternate_form = job.reg_data[0];
            REG_UPPER_CASE:     fmt_cfg.upper_case = job.reg_data[0];
            default: ;
          endcase
        end
        void'(format_jobs.pop_front());
      end
    end
    start <= go;
    wr_en <= write_now;
  end

  always @(posedge clk) begin : observe
    fmt_char_t want;
    xfer_in = !rst && start && !busy;
    if (xfer_in) format_value(value_bits);
    if (!rst && strobe) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected char: expected none, got ch=%h last=%b empty=%b cut=%b",
                 $time, text_char, last_char, empty_text, cut_short);
      end else begin
        want = pending_chars.pop_front();
        if ({text_char, last_char, empty_text, cut_short} !== want) begin
          errors++;
          $display("%0t: mismatch: expected ch/last/empty/cut %h/%b/%b/%b, got %h/%b/%b/%b",
                   $time, want.ch, want.last, want.empty, want.cut,
                   text_char, last_char, empty_text, cut_short);
        end
      end
    end
    if (rst || xfer_in || strobe || wr_en) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    // defaults: signed decimal, no minimum
    cur_gap = 37;
    put_value(64'h0);
    put_value(64'h1);
    put_value(~64'h0);
    put_value(64'h8000_0000_0000_0000);
    put_value(64'h7FFF_FFFF_FFFF_FFFF);
    put_reg(REG_SIGN_MODE, {6'b0, SIGN_PLUS});
    put_value(64'd12345);
    put_reg(REG_SIGN_MODE, {6'b0, SIGN_SPACE});
    put_value(64'd7);
    put_value(-64'd7);
    put_reg(REG_SIGN_MODE, {6'h3F, SIGN_SPARE});
    put_value(64'd42);
    // zero with precision zero gives empty text
    put_reg(REG_MIN_DIGITS, 8'h00);
    put_value(64'h0);
    put_value(64'd9);
    put_reg(REG_RADIX_MODE, {5'b0, RADIX_UDEC});
    put_reg(REG_MIN_DIGITS, 8'd25);
    put_value(~64'h0);
    put_value(64'h0);
    put_reg(REG_RADIX_MODE, {5'h1F, RADIX_BIN});
    put_reg(REG_ALTERNATE_FORM, 8'h01);
    put_reg(REG_MIN_DIGITS, 8'hFF);
    put_value(~64'h0);
    put_value(64'd5);
    put_reg(REG_MIN_DIGITS, 8'd70);
    put_value(64'h1);
    put_reg(REG_RADIX_MODE, {5'b0, RADIX_OCT});
    put_reg(REG_MIN_DIGITS, 8'h80);
    put_value(64'd8);
    put_value(~64'h0);
    put_reg(REG_MIN_DIGITS, 8'd30);
    put_value(64'd8);
    put_reg(REG_RADIX_MODE, {5'b0, RADIX_HEX});
    put_reg(REG_UPPER_CASE, 8'hFF);
    put_reg(REG_MIN_DIGITS, 8'h7F);
    put_value(64'hDEAD_BEEF_CAFE_F00D);
    put_reg(REG_MIN_DIGITS, 8'hFE);
    put_value(64'hDEAD_BEEF_CAFE_F00D);
    put_reg(REG_UPPER_CASE, 8'hFE);
    put_reg(REG_RADIX_MODE, {5'b0, RADIX_SPARE});
    put_value(64'hABCD_EF01_2345_6789);
    put_reg(REG_SPARE, 8'hFF);
    put_value(64'hFF);
    put_reg(REG_ALTERNATE_FORM, 8'h00);
    put_reg(REG_MIN_DIGITS, 8'd64);
    put_value(64'h3);

    for (int seg = 0; seg < 30; seg++) begin
      cur_gap = (seg < 10) ? 37 : (seg < 20) ? 71 : 0;
      put_reg(REG_RADIX_MODE, {5'($urandom),
                               ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'($urandom_range(0, 4))});
      if ($urandom_range(0, 1)) put_reg(REG_MIN_DIGITS, pick_min_digits());
      if ($urandom_range(0, 1)) put_reg(REG_SIGN_MODE, 8'($urandom));
      if ($urandom_range(0, 1)) put_reg(REG_ALTERNATE_FORM, 8'($urandom));
      if ($urandom_range(0, 1)) put_reg(REG_UPPER_CASE, 8'($urandom));
      if ($urandom_range(0, 5) == 0) put_reg(3'($urandom_range(5, 7)), 8'($urandom));
      n = $urandom_range(10, 16);
      for (int k = 0; k < n; k++) begin
        put_value(pick_value());
        if ($urandom_range(0, 39) == 0) put_drain();
      end
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (format_jobs.size() != 0 || start || pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      errors++;
      $display("%0t: %0d expected chars never arrived, next expected ch=%h, got none",
               $time, pending_chars.size(), pending_chars[0].ch);
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
